### rtl/shlm_pkg.sv
// Package for the sorted hit list merge/accumulate block.
// Holds the transaction structs, field widths and control structs between front and back.
// No dependencies.
package shlm_pkg;

   localparam int ID_W         = 32;
   localparam int ENERGY_W     = 32;
   localparam int EXTRA_W      = 64;
   localparam int CNT_W        = 6;   // holds a list count up to 63
   localparam int MAX_HITS_DEF = 32;
   localparam int EXTRA_BITS_DEF = 64;

   localparam logic [1:0] MODE_LOAD_A = 2'd0;
   localparam logic [1:0] MODE_LOAD_B = 2'd1;
   localparam logic [1:0] MODE_END    = 2'd2;

   typedef struct packed {
      logic [1:0]                 mode;
      logic [ID_W-1:0]            hit_id;
      logic signed [ENERGY_W-1:0] hit_energy;
      logic [EXTRA_W-1:0]         extra_features;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]            merged_id;
      logic signed [ENERGY_W-1:0] energy_first;
      logic signed [ENERGY_W-1:0] energy_second;
      logic [EXTRA_W-1:0]         merged_extra;
      logic                       last_of_event;
      logic                       empty_event;
      logic                       overflowed;
   } rsp_type;

   // event hand-off from front to back
   typedef struct packed {
      logic             valid;
      logic [CNT_W-1:0] count_a;
      logic [CNT_W-1:0] count_b;
      logic             overflow;
   } evt_type;

   // back status toward front
   typedef struct packed {
      logic ack;
      logic done;
      logic idle;
   } bk_stat_type;

endpackage

### rtl/shlm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module shlm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/shlm_front.sv
// Front of the merge block: accepts load and end-of-event transactions, writes list RAMs,
// keeps counts and overflow, hands events to the back. Depends on shlm_pkg.
module shlm_front #(
   parameter int MAX_HITS   = shlm_pkg::MAX_HITS_DEF,
   parameter int EXTRA_BITS = shlm_pkg::EXTRA_BITS_DEF,
   localparam int AW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1,
   localparam int EW = shlm_pkg::ID_W + shlm_pkg::ENERGY_W + EXTRA_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  shlm_pkg::req_type     req_data,
   output logic                  we_a,
   output logic                  we_b,
   output logic [AW-1:0]         waddr,
   output logic [EW-1:0]         wdata,
   output shlm_pkg::evt_type     evt,
   input  shlm_pkg::bk_stat_type bk_stat
);

   localparam logic [shlm_pkg::CNT_W-1:0] MaxCnt = shlm_pkg::CNT_W'(MAX_HITS);

   logic [shlm_pkg::CNT_W-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic                       ovf_ff, ovf_in;
   logic                       lock_ff, lock_in;
   shlm_pkg::evt_type          evt_ff, evt_in;
   logic                       accept;

   assign full   = lock_ff;
   assign accept = push && !lock_ff;
   assign evt    = evt_ff;
   assign wdata  = {req_data.hit_id, req_data.hit_energy,
                    req_data.extra_features[EXTRA_BITS-1:0]};
   assign waddr  = (req_data.mode == shlm_pkg::MODE_LOAD_A) ? cnt_a_ff[AW-1:0]
                                                            : cnt_b_ff[AW-1:0];
   assign we_a   = accept && req_data.mode == shlm_pkg::MODE_LOAD_A && cnt_a_ff < MaxCnt;
   assign we_b   = accept && req_data.mode == shlm_pkg::MODE_LOAD_B && cnt_b_ff < MaxCnt;

   always_comb begin
      cnt_a_in = cnt_a_ff;
      cnt_b_in = cnt_b_ff;
      ovf_in   = ovf_ff;
      lock_in  = lock_ff;
      evt_in   = evt_ff;
      if (bk_stat.ack) begin
         evt_in.valid = 1'b0;
      end
      if (bk_stat.done) begin
         lock_in = 1'b0;
      end
      if (accept) begin
         unique case (req_data.mode)
            shlm_pkg::MODE_LOAD_A: begin
               if (we_a) cnt_a_in = cnt_a_ff + 1'b1;
               else      ovf_in   = 1'b1;
            end
            shlm_pkg::MODE_LOAD_B: begin
               if (we_b) cnt_b_in = cnt_b_ff + 1'b1;
               else      ovf_in   = 1'b1;
            end
            shlm_pkg::MODE_END: begin
               // hand the event over and hold off loads until the merge is out
               evt_in   = '{valid: 1'b1, count_a: cnt_a_ff, count_b: cnt_b_ff,
                            overflow: ovf_ff};
               lock_in  = 1'b1;
               cnt_a_in = '0;
               cnt_b_in = '0;
               ovf_in   = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_a_ff <= '0;
         cnt_b_ff <= '0;
         ovf_ff   <= 1'b0;
         lock_ff  <= 1'b0;
         evt_ff   <= '0;
      end else begin
         cnt_a_ff <= cnt_a_in;
         cnt_b_ff <= cnt_b_in;
         ovf_ff   <= ovf_in;
         lock_ff  <= lock_in;
         evt_ff   <= evt_in;
      end
   end

endmodule

### rtl/shlm_back.sv
// Back of the merge block: two-pointer merge over the list RAMs, folds equal ids,
// saturating accumulation and the result register. Depends on shlm_pkg.
module shlm_back #(
   parameter int MAX_HITS   = shlm_pkg::MAX_HITS_DEF,
   parameter int EXTRA_BITS = shlm_pkg::EXTRA_BITS_DEF,
   localparam int AW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1,
   localparam int EW = shlm_pkg::ID_W + shlm_pkg::ENERGY_W + EXTRA_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  separate,
   input  shlm_pkg::evt_type     evt,
   output shlm_pkg::bk_stat_type bk_stat,
   output logic [AW-1:0]         raddr_a,
   output logic [AW-1:0]         raddr_b,
   input  logic [EW-1:0]         rdata_a,
   input  logic [EW-1:0]         rdata_b,
   output logic                  empty,
   input  logic                  pop,
   output shlm_pkg::rsp_type     rsp_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_CMP   = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   localparam int XL = EXTRA_BITS;
   localparam int EL = XL;
   localparam int IL = XL + shlm_pkg::ENERGY_W;

   typedef logic signed [shlm_pkg::ENERGY_W-1:0] nrg_type;

   function automatic nrg_type sat_add(nrg_type a, nrg_type b);
      logic signed [shlm_pkg::ENERGY_W:0] s;
      s = {a[shlm_pkg::ENERGY_W-1], a} + {b[shlm_pkg::ENERGY_W-1], b};
      if (s[shlm_pkg::ENERGY_W] != s[shlm_pkg::ENERGY_W-1]) begin
         sat_add = s[shlm_pkg::ENERGY_W] ? {1'b1, {(shlm_pkg::ENERGY_W-1){1'b0}}}
                                         : {1'b0, {(shlm_pkg::ENERGY_W-1){1'b1}}};
      end else begin
         sat_add = s[shlm_pkg::ENERGY_W-1:0];
      end
   endfunction

   logic [1:0]                 state_ff, state_in;
   logic [shlm_pkg::CNT_W-1:0] ia_ff, ia_in, ib_ff, ib_in, ca_ff, ca_in, cb_ff, cb_in;
   logic                       ovf_ff, ovf_in;
   logic                       pend_b_ff, pend_b_in;
   logic                       cur_v_ff, cur_v_in;
   shlm_pkg::rsp_type          cur_ff, cur_in;
   logic                       rsp_v_ff, rsp_v_in;
   shlm_pkg::rsp_type          rsp_ff, rsp_in;

   logic [shlm_pkg::ID_W-1:0]  ida, idb, hid;
   nrg_type                    ea, eb, he;
   logic [shlm_pkg::EXTRA_W-1:0] hx;
   logic                       a_done, b_done, take_b, equal, fold, col2, out_free;

   assign ida = rdata_a[EW-1:IL];
   assign idb = rdata_b[EW-1:IL];
   assign ea  = rdata_a[IL-1:EL];
   assign eb  = rdata_b[IL-1:EL];
   assign raddr_a = ia_ff[AW-1:0];
   assign raddr_b = ib_ff[AW-1:0];

   assign a_done   = ia_ff == ca_ff;
   assign b_done   = ib_ff == cb_ff;
   assign equal    = !pend_b_ff && !a_done && !b_done && ida == idb;
   assign take_b   = pend_b_ff || a_done || (!b_done && idb < ida);
   assign hid      = take_b ? idb : ida;
   assign he       = take_b ? eb : ea;
   assign hx       = take_b ? shlm_pkg::EXTRA_W'(rdata_b[XL-1:0])
                            : shlm_pkg::EXTRA_W'(rdata_a[XL-1:0]);
   assign fold     = cur_v_ff && cur_ff.merged_id == hid;
   assign col2     = separate && take_b;
   assign out_free = !rsp_v_ff || pop;

   assign empty    = !rsp_v_ff;
   assign rsp_data = rsp_ff;
   assign bk_stat  = '{ack: state_ff == ST_IDLE && evt.valid,
                       done: state_ff == ST_FLUSH && out_free,
                       idle: state_ff == ST_IDLE};

   always_comb begin
      state_in  = state_ff;
      ia_in     = ia_ff;
      ib_in     = ib_ff;
      ca_in     = ca_ff;
      cb_in     = cb_ff;
      ovf_in    = ovf_ff;
      pend_b_in = pend_b_ff;
      cur_v_in  = cur_v_ff;
      cur_in    = cur_ff;
      rsp_v_in  = rsp_v_ff && !pop;
      rsp_in    = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (evt.valid) begin
               ca_in     = evt.count_a;
               cb_in     = evt.count_b;
               ovf_in    = evt.overflow;
               ia_in     = '0;
               ib_in     = '0;
               pend_b_in = 1'b0;
               cur_v_in  = 1'b0;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            // addresses are out; data lands next cycle
            state_in = (a_done && b_done) ? ST_FLUSH : ST_CMP;
         end
         ST_CMP: begin
            if (fold) begin
               if (col2) cur_in.energy_second = sat_add(cur_ff.energy_second, he);
               else      cur_in.energy_first  = sat_add(cur_ff.energy_first, he);
            end
            if (fold || !cur_v_ff || out_free) begin
               if (!fold) begin
                  if (cur_v_ff) begin
                     rsp_v_in = 1'b1;
                     rsp_in   = cur_ff;
                  end
                  cur_v_in = 1'b1;
                  cur_in   = '{merged_id: hid,
                               energy_first: col2 ? '0 : he,
                               energy_second: col2 ? he : '0,
                               merged_extra: hx, last_of_event: 1'b0,
                               empty_event: 1'b0, overflowed: ovf_ff};
               end
               if (take_b) ib_in = ib_ff + 1'b1;
               else        ia_in = ia_ff + 1'b1;
               // equal ids: list B hit follows and folds into this one
               pend_b_in = equal;
               state_in  = ST_READ;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_v_in = 1'b1;
               if (cur_v_ff) begin
                  rsp_in               = cur_ff;
                  rsp_in.last_of_event = 1'b1;
               end else begin
                  rsp_in = '{merged_id: '0, energy_first: '0, energy_second: '0,
                             merged_extra: '0, last_of_event: 1'b1,
                             empty_event: 1'b1, overflowed: ovf_ff};
               end
               cur_v_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pend_b_ff <= 1'b0;
         cur_v_ff  <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pend_b_ff <= pend_b_in;
         cur_v_ff  <= cur_v_in;
         rsp_v_ff  <= rsp_v_in;
      end
      ia_ff  <= ia_in;
      ib_ff  <= ib_in;
      ca_ff  <= ca_in;
      cb_ff  <= cb_in;
      ovf_ff <= ovf_in;
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

endmodule

### rtl/sorted_hit_list_merge_accumulate_top.sv
// Top level of the sorted hit list merge/accumulate block.
// Depends on shlm_pkg, shlm_ram, shlm_front and shlm_back.
//
// Usage:
//  - Input queue (push/full/req_data): mode 0 loads a hit into list A, mode 1 into
//    list B, mode 2 ends the event, mode 3 is taken and ignored. Loads beyond
//    MAX_HITS per list are dropped and flagged on every result of the event.
//  - On end of event the merge runs: each hit is read from the list RAMs
//    (registered read, then compare and fold), then the last open hit is flushed.
//    full stays high from the end-of-event transaction until the last result has
//    gone into the result register.
//  - Result queue (empty/pop/rsp_data): one result register; an event with no
//    hits gives a single marker with empty_event and last_of_event set.
//  - csr_we/csr_wdata write separate_energy_columns; write only while idle.
//  - Reset (synchronous, active high) clears counts, overflow flag, merge state
//    and empties the result register; list contents are not cleared.
//  - When pop stays low the merge holds at the next hit that needs to open a new
//    result, and loads for the next event wait behind full.
module sorted_hit_list_merge_accumulate_top #(
   parameter int MAX_HITS   = shlm_pkg::MAX_HITS_DEF,
   parameter int EXTRA_BITS = shlm_pkg::EXTRA_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  shlm_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output shlm_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_wdata
);

   localparam int AW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
   localparam int EW = shlm_pkg::ID_W + shlm_pkg::ENERGY_W + EXTRA_BITS;

   logic                  separate_ff;
   logic                  we_a, we_b;
   logic [AW-1:0]         waddr, raddr_a, raddr_b;
   logic [EW-1:0]         wdata, rdata_a, rdata_b;
   shlm_pkg::evt_type     evt;
   shlm_pkg::bk_stat_type bk_stat;

   // hold the column mode between writes
   always_ff @(posedge clock) begin
      if (reset) begin
         separate_ff <= 1'b0;
      end else if (csr_we) begin
         separate_ff <= csr_wdata;
      end
   end

   shlm_ram #(.WIDTH(EW), .DEPTH(MAX_HITS)) u_ram_a (
      .clock(clock), .we(we_a), .waddr(waddr), .wdata(wdata),
      .raddr(raddr_a), .rdata(rdata_a));

   shlm_ram #(.WIDTH(EW), .DEPTH(MAX_HITS)) u_ram_b (
      .clock(clock), .we(we_b), .waddr(waddr), .wdata(wdata),
      .raddr(raddr_b), .rdata(rdata_b));

   shlm_front #(.MAX_HITS(MAX_HITS), .EXTRA_BITS(EXTRA_BITS)) u_front (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .we_a(we_a), .we_b(we_b), .waddr(waddr), .wdata(wdata),
      .evt(evt), .bk_stat(bk_stat));

   shlm_back #(.MAX_HITS(MAX_HITS), .EXTRA_BITS(EXTRA_BITS)) u_back (
      .clock(clock), .reset(reset), .separate(separate_ff), .evt(evt),
      .bk_stat(bk_stat), .raddr_a(raddr_a), .raddr_b(raddr_b),
      .rdata_a(rdata_a), .rdata_b(rdata_b),
      .empty(empty), .pop(pop), .rsp_data(rsp_data));

`ifndef SYNTH
   // loads are only taken while the merge engine is idle
   a_full_covers_merge: assert property (@(posedge clock) disable iff (reset)
      !full |-> bk_stat.idle)
      else $error("input open while merge busy");

   // an empty-event marker is always the last result of its event
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.empty_event) |-> rsp_data.last_of_event)
      else $error("empty marker without last flag");

   // the event hand-off is only seen while the input side is locked
   a_evt_locked: assert property (@(posedge clock) disable iff (reset)
      evt.valid |-> full)
      else $error("event pending with input open");

   // input opens in the cycle after reset
   a_reset_open: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !full)
      else $error("input not open after reset");
`endif

endmodule
